[hw/rtl/i2p_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, character codes and helper functions for the infix to
// postfix converter.
// ----------------------------------------------------------------------------

package i2p_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EQ    = 8'h3d;

	localparam logic [1:0] RANK_NONE = 2'd0;
	localparam logic [1:0] RANK_ADD  = 2'd1;
	localparam logic [1:0] RANK_MUL  = 2'd2;

	typedef enum logic [2:0] {
		KIND_OP,
		KIND_NUM,
		KIND_OPEN,
		KIND_CLOSE,
		KIND_IGN,
		KIND_END
	} kind_t;

	typedef enum logic [1:0] {
		SEL_SPACE,
		SEL_TOP,
		SEL_ITEM,
		SEL_NUL
	} sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NUM_SP,
		ST_NUM_CH,
		ST_OPEN,
		ST_OP_SP,
		ST_OP_CH,
		ST_PUSH,
		ST_PC_CHK,
		ST_PC_SP,
		ST_PC_CH,
		ST_PC_DROP,
		ST_FL_CHK,
		ST_FL_SP,
		ST_FL_CH,
		ST_FL_NUL
	} state_t;

	typedef struct packed {
		logic accept;
		logic emit;
		sel_t sel;
		logic last;
		logic pop;
		logic push;
		logic drop_open;
		logic clear;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  space_pending;
		logic  out_free;
		logic  cnt_zero;
		logic  cnt_one;
		logic  top_pops;
		logic  top_open;
		logic  next_open;
	} stat_t;

	function automatic logic [1:0] rank_of(input logic [7:0] c);
		logic [1:0] r;
		r = RANK_NONE;
		if (c == CH_PLUS || c == CH_MINUS) r = RANK_ADD;
		if (c == CH_STAR || c == CH_SLASH) r = RANK_MUL;
		return r;
	endfunction

	function automatic logic is_numeric(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT;
	endfunction

	// stacked entry t leaves the stack ahead of incoming operator c
	function automatic logic pops(input logic [7:0] t, input logic [7:0] c);
		return (t != CH_OPEN) && (rank_of(t) >= rank_of(c));
	endfunction

	function automatic kind_t kind_of(input logic [7:0] c, input logic last_item);
		kind_t k;
		if (last_item) k = KIND_END;
		else if (is_numeric(c)) k = KIND_NUM;
		else if (c == CH_OPEN) k = KIND_OPEN;
		else if (c == CH_CLOSE) k = KIND_CLOSE;
		else if (c == CH_EQ) k = KIND_IGN;
		else k = KIND_OP;
		return k;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/i2p_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer: takes one character, then walks the emit, pop and push steps
// that the character calls for, with at most one output beat per step.
// ----------------------------------------------------------------------------

module i2p_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire i2p_pkg::stat_t  stat,
	output i2p_pkg::cmd_t        cmd
);

	i2p_pkg::state_t state_q;
	i2p_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2p_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != i2p_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sel = i2p_pkg::SEL_SPACE;
		unique case (state_q)
			i2p_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (stat.kind)
						i2p_pkg::KIND_END:   state_d = i2p_pkg::ST_FL_CHK;
						i2p_pkg::KIND_NUM:   state_d = stat.space_pending ?
						                               i2p_pkg::ST_NUM_SP : i2p_pkg::ST_NUM_CH;
						i2p_pkg::KIND_OPEN:  state_d = i2p_pkg::ST_OPEN;
						i2p_pkg::KIND_CLOSE: state_d = i2p_pkg::ST_PC_CHK;
						i2p_pkg::KIND_IGN:   state_d = i2p_pkg::ST_IDLE;
						i2p_pkg::KIND_OP:    state_d = i2p_pkg::ST_OP_SP;
						default:             state_d = i2p_pkg::ST_IDLE;
					endcase
				end
			end
			i2p_pkg::ST_NUM_SP: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = i2p_pkg::SEL_SPACE;
					state_d  = i2p_pkg::ST_NUM_CH;
				end
			end
			i2p_pkg::ST_NUM_CH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = i2p_pkg::SEL_ITEM;
					cmd.last = 1'b1;
					state_d  = i2p_pkg::ST_IDLE;
				end
			end
			i2p_pkg::ST_OPEN: begin
				cmd.push = 1'b1;
				state_d  = i2p_pkg::ST_IDLE;
			end
			// space before the pops and after each popped operator
			i2p_pkg::ST_OP_SP: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = i2p_pkg::SEL_SPACE;
					cmd.last = !stat.top_pops;
					state_d  = stat.top_pops ? i2p_pkg::ST_OP_CH : i2p_pkg::ST_PUSH;
				end
			end
			i2p_pkg::ST_OP_CH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = i2p_pkg::SEL_TOP;
					cmd.pop  = 1'b1;
					state_d  = i2p_pkg::ST_OP_SP;
				end
			end
			i2p_pkg::ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = i2p_pkg::ST_IDLE;
			end
			i2p_pkg::ST_PC_CHK: begin
				if (stat.cnt_zero) state_d = i2p_pkg::ST_IDLE;
				else if (stat.top_open) state_d = i2p_pkg::ST_PC_DROP;
				else state_d = i2p_pkg::ST_PC_SP;
			end
			i2p_pkg::ST_PC_SP: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = i2p_pkg::SEL_SPACE;
					state_d  = i2p_pkg::ST_PC_CH;
				end
			end
			i2p_pkg::ST_PC_CH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = i2p_pkg::SEL_TOP;
					cmd.last = stat.cnt_one || stat.next_open;
					cmd.pop  = 1'b1;
					state_d  = i2p_pkg::ST_PC_CHK;
				end
			end
			i2p_pkg::ST_PC_DROP: begin
				cmd.pop       = 1'b1;
				cmd.drop_open = 1'b1;
				state_d       = i2p_pkg::ST_IDLE;
			end
			i2p_pkg::ST_FL_CHK: begin
				state_d = stat.cnt_zero ? i2p_pkg::ST_FL_NUL : i2p_pkg::ST_FL_SP;
			end
			i2p_pkg::ST_FL_SP: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = i2p_pkg::SEL_SPACE;
					state_d  = i2p_pkg::ST_FL_CH;
				end
			end
			i2p_pkg::ST_FL_CH: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.sel       = i2p_pkg::SEL_TOP;
					cmd.pop       = 1'b1;
					// leftover open parens leave the paren count as well
					cmd.drop_open = stat.top_open;
					state_d       = i2p_pkg::ST_FL_CHK;
				end
			end
			i2p_pkg::ST_FL_NUL: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.sel   = i2p_pkg::SEL_NUL;
					cmd.last  = 1'b1;
					cmd.clear = 1'b1;
					state_d   = i2p_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = i2p_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/i2p_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_dp
// Datapath: operator stack memory with a cached top entry, bookkeeping
// registers and the output register.
// ----------------------------------------------------------------------------

module i2p_dp #(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      in_char,
	input  wire logic            end_of_expr,
	input  wire i2p_pkg::cmd_t   cmd,
	output i2p_pkg::stat_t       stat,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [7:0]           out_char,
	output logic                 last_of_run,
	output logic                 syntax_error
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);

	logic [7:0]    mem [STACK_DEPTH];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] lp_q;
	logic [7:0]    char_q;
	logic [7:0]    top_q;
	logic [7:0]    rd_q;
	logic          sbd_q;
	logic          err_q;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_last_q;
	logic          out_err_q;

	i2p_pkg::kind_t in_kind;
	logic           full;
	logic           in_err;
	logic [7:0]     emit_char;
	logic [IW-1:0]  rd_addr;

	assign in_kind = i2p_pkg::kind_of(in_char, end_of_expr);
	assign full    = (cnt_q == CW'(STACK_DEPTH));
	// entry just below the top, read every cycle
	assign rd_addr = IW'(cnt_q - CW'(2));

	// error of this item is known at accept: a push fails only when nothing pops
	always_comb begin
		case (in_kind)
			i2p_pkg::KIND_OPEN:  in_err = full;
			i2p_pkg::KIND_CLOSE: in_err = (lp_q == '0);
			i2p_pkg::KIND_OP:    in_err = full && !i2p_pkg::pops(top_q, in_char);
			default:             in_err = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.sel)
			i2p_pkg::SEL_SPACE: emit_char = i2p_pkg::CH_SPACE;
			i2p_pkg::SEL_TOP:   emit_char = top_q;
			i2p_pkg::SEL_ITEM:  emit_char = char_q;
			default:            emit_char = i2p_pkg::CH_NUL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			lp_q        <= '0;
			sbd_q       <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			if (cmd.clear) begin
				cnt_q <= '0;
				lp_q  <= '0;
				sbd_q <= 1'b0;
				err_q <= 1'b0;
			end else begin
				if (cmd.accept) err_q <= err_q | in_err;
				if (cmd.emit) begin
					sbd_q <= !(i2p_pkg::is_numeric(emit_char) ||
					           emit_char == i2p_pkg::CH_SPACE);
				end
				if (cmd.push) begin
					if (full) begin
						err_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CW'(1);
						if (char_q == i2p_pkg::CH_OPEN) lp_q <= lp_q + CW'(1);
					end
				end
				if (cmd.pop) begin
					cnt_q <= cnt_q - CW'(1);
					if (cmd.drop_open) lp_q <= lp_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) char_q <= in_char;
		if (cmd.push && !full) begin
			mem[cnt_q[IW-1:0]] <= char_q;
			top_q              <= char_q;
		end
		if (cmd.pop) top_q <= rd_q;
		rd_q <= mem[rd_addr];
		if (cmd.emit) begin
			out_char_q <= emit_char;
			out_last_q <= cmd.last;
			out_err_q  <= err_q;
		end
	end

	assign stat.kind          = in_kind;
	assign stat.space_pending = sbd_q;
	assign stat.out_free      = !out_valid_q || !out_stall;
	assign stat.cnt_zero      = (cnt_q == '0);
	assign stat.cnt_one       = (cnt_q == CW'(1));
	assign stat.top_pops      = (cnt_q != '0) && i2p_pkg::pops(top_q, char_q);
	assign stat.top_open      = (cnt_q != '0) && (top_q == i2p_pkg::CH_OPEN);
	assign stat.next_open     = (rd_q == i2p_pkg::CH_OPEN);

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign last_of_run  = out_last_q;
	assign syntax_error = out_err_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_lp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lp_q <= cnt_q)
		else $error("open paren count beyond stack count");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("beat loaded over a waiting beat");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (cnt_q != '0))
		else $error("pop from empty stack");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (cnt_q == '0) && !err_q && !sbd_q)
		else $error("state not cleared after end of expression");
`endif

endmodule

`default_nettype wire

[hw/rtl/infix_to_postfix_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------

// One infix character is taken per input beat and turned into zero or more
// postfix output beats; last_of_run marks the final beat of each character
// and syntax_error carries the sticky error flag. An item is first accepted,
// then takes one controller state per output beat it produces, plus
// one for a push, one for dropping the matching open paren of a close paren
// and one for each stack check of a close paren or end item; a state that
// emits waits while the output register is held. This pacing is set by the
// single output register (one beat per cycle while out_stall allows) and by
// the one read port of the operator stack, whose registered read supplies
// the entry below the top. A new item is not taken until the steps of the
// current one are done; a finished beat may still wait in the output
// register while the next item is accepted. The stack holds STACK_DEPTH
// entries.

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_char,
	input  wire logic       end_of_expr,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_char,
	output logic            last_of_run,
	output logic            syntax_error
);

	i2p_pkg::cmd_t  cmd;
	i2p_pkg::stat_t stat;

	i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	i2p_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_char      (in_char),
		.end_of_expr  (end_of_expr),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.last_of_run  (last_of_run),
		.syntax_error (syntax_error)
	);

endmodule

`default_nettype wire

[verif/infix_to_postfix_converter_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_test
// Self-checking bench for the shunting-yard converter. Infix characters are
// sent with random gaps while a local copy of the operator stack predicts
// every postfix beat. Each output beat is checked field by field against the
// oldest prediction. Output stalls are random, with one long hold-off.
// ----------------------------------------------------------------------------

module infix_to_postfix_converter_test;

	localparam int STACK_DEPTH = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       err;
	} postfix_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_char = 8'h00;
	logic       end_of_expr = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       last_of_run;
	logic       syntax_error;

	// predicted converter state
	logic [7:0]  op_model [STACK_DEPTH];
	int unsigned depth_model = 0;
	bit          space_model = 1'b0;
	bit          err_model = 1'b0;

	postfix_beat_t run_beats [$];
	postfix_beat_t expected_beats [$];

	int unsigned items_sent = 0;
	int unsigned fail_count = 0;
	int unsigned idle_cycles = 0;
	bit          gaps_on = 1'b1;
	bit          hold_request = 1'b0;

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_char(in_char),
		.end_of_expr(end_of_expr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.last_of_run(last_of_run),
		.syntax_error(syntax_error)
	);

	always #10 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic int op_rank(input logic [7:0] c);
		if (c == i2p_pkg::CH_PLUS || c == i2p_pkg::CH_MINUS) return 1;
		if (c == i2p_pkg::CH_STAR || c == i2p_pkg::CH_SLASH) return 2;
		return 0;
	endfunction

	function automatic bit is_number_char(input logic [7:0] c);
		return (c >= i2p_pkg::CH_ZERO && c <= i2p_pkg::CH_NINE) || c == i2p_pkg::CH_DOT;
	endfunction

	function automatic void put_char(input logic [7:0] c);
		postfix_beat_t b;
		b.ch = c;
		b.last = 1'b0;
		b.err = 1'b0;
		run_beats.push_back(b);
		space_model = !(is_number_char(c) || c == i2p_pkg::CH_SPACE);
	endfunction

	function automatic void push_model(input logic [7:0] c);
		if (depth_model >= STACK_DEPTH) begin
			err_model = 1'b1;
		end else begin
			op_model[depth_model] = c;
			depth_model++;
		end
	endfunction

	function automatic logic [7:0] pop_model();
		depth_model--;
		return op_model[depth_model];
	endfunction

	function automatic void predict_postfix(input logic [7:0] c, input logic e);
		bit flag;
		int r;
		postfix_beat_t b;
		run_beats.delete();
		if (e) begin
			while (depth_model > 0) begin
				put_char(i2p_pkg::CH_SPACE);
				put_char(pop_model());
			end
			put_char(i2p_pkg::CH_NUL);
			flag = err_model;
			depth_model = 0;
			space_model = 1'b0;
			err_model = 1'b0;
		end else begin
			if (is_number_char(c)) begin
				if (space_model)
					put_char(i2p_pkg::CH_SPACE);
				put_char(c);
			end else if (c == i2p_pkg::CH_OPEN) begin
				push_model(c);
			end else if (c == i2p_pkg::CH_CLOSE) begin
				while (depth_model > 0 && op_model[depth_model - 1] != i2p_pkg::CH_OPEN) begin
					put_char(i2p_pkg::CH_SPACE);
					put_char(pop_model());
				end
				if (depth_model > 0)
					void'(pop_model());
				else
					err_model = 1'b1;
			end else if (c != i2p_pkg::CH_EQ) begin
				r = op_rank(c);
				put_char(i2p_pkg::CH_SPACE);
				while (depth_model > 0 && op_model[depth_model - 1] != i2p_pkg::CH_OPEN &&
				       op_rank(op_model[depth_model - 1]) >= r) begin
					put_char(pop_model());
					put_char(i2p_pkg::CH_SPACE);
				end
				push_model(c);
			end
			flag = err_model;
		end
		foreach (run_beats[i]) begin
			b = run_beats[i];
			b.err = flag;
			b.last = (i == run_beats.size() - 1);
			expected_beats.push_back(b);
		end
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a rising edge, returns at the edge where the beat is taken
	task automatic send_char(input logic [7:0] c, input logic e = 1'b0);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		end_of_expr <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_postfix(c, e);
		items_sent++;
	endtask

	task automatic send_end();
		send_char(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [7:0] pick_number_char();
		if ($urandom_range(0, 9) == 0)
			return i2p_pkg::CH_DOT;
		return i2p_pkg::CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 9))
			0: return 8'h5e;
			1: return 8'($urandom_range(8'h61, 8'h7a));
			2, 3: return i2p_pkg::CH_PLUS;
			4, 5: return i2p_pkg::CH_MINUS;
			6, 7: return i2p_pkg::CH_STAR;
			default: return i2p_pkg::CH_SLASH;
		endcase
	endfunction

	task automatic send_expression(input int unsigned max_depth);
		int unsigned terms;
		int unsigned depth;
		terms = $urandom_range(1, 6);
		depth = 0;
		for (int unsigned k = 0; k < terms; k++) begin
			while (depth < max_depth && $urandom_range(0, 3) == 0) begin
				send_char(i2p_pkg::CH_OPEN);
				depth++;
			end
			repeat ($urandom_range(1, 3))
				send_char(pick_number_char());
			while (depth > 0 && $urandom_range(0, 2) == 0) begin
				send_char(i2p_pkg::CH_CLOSE);
				depth--;
			end
			if (k != terms - 1)
				send_char(pick_operator());
		end
		// now and then leave parens open or add a stray close
		if ($urandom_range(0, 9) != 0) begin
			while (depth > 0) begin
				send_char(i2p_pkg::CH_CLOSE);
				depth--;
			end
		end else if ($urandom_range(0, 1) == 0) begin
			send_char(i2p_pkg::CH_CLOSE);
		end
		if ($urandom_range(0, 1) == 0)
			send_char(i2p_pkg::CH_EQ);
		send_end();
	endtask

	// ---------------- tests ----------------

	task automatic test_basic_expression();
		send_char(i2p_pkg::CH_ZERO + 8'd1);
		send_char(i2p_pkg::CH_PLUS);
		send_char(i2p_pkg::CH_ZERO + 8'd2);
		send_char(i2p_pkg::CH_STAR);
		send_char(i2p_pkg::CH_OPEN);
		send_char(i2p_pkg::CH_NINE);
		send_char(i2p_pkg::CH_MINUS);
		send_char(i2p_pkg::CH_ZERO);
		send_char(i2p_pkg::CH_CLOSE);
		send_char(i2p_pkg::CH_SLASH);
		send_char(i2p_pkg::CH_DOT);
		send_char(i2p_pkg::CH_ZERO + 8'd5);
		send_char(i2p_pkg::CH_EQ);
		send_end();
	endtask

	task automatic test_odd_characters();
		// close paren with nothing stacked, then NUL, space and 0xff as operators
		send_char(i2p_pkg::CH_CLOSE);
		send_char(i2p_pkg::CH_NUL);
		send_char(i2p_pkg::CH_SPACE);
		send_char(8'hff);
		send_char(i2p_pkg::CH_CLOSE);
		send_end();
	endtask

	task automatic test_stack_overflow();
		repeat (STACK_DEPTH)
			send_char(i2p_pkg::CH_OPEN);
		send_char(i2p_pkg::CH_STAR);
		send_char(i2p_pkg::CH_OPEN);
		send_end();
	endtask

	task automatic test_random_expressions();
		while (items_sent < 170) begin
			gaps_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 14) == 0)
				repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2))
					send_char(i2p_pkg::CH_OPEN);
			send_expression(4);
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_noise();
		logic [7:0] c;
		repeat (60) begin
			case ($urandom_range(0, 7))
				0: c = i2p_pkg::CH_OPEN;
				1: c = i2p_pkg::CH_CLOSE;
				2: c = i2p_pkg::CH_EQ;
				3: c = pick_operator();
				4: c = pick_number_char();
				default: c = 8'($urandom_range(0, 255));
			endcase
			send_char(c, ($urandom_range(0, 7) == 0));
		end
		send_end();
	endtask

	task automatic test_output_hold();
		gaps_on = 1'b0;
		hold_request = 1'b1;
		repeat (4)
			send_expression(3);
		gaps_on = 1'b1;
	endtask

	// ---------------- receiver ----------------

	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (!gaps_on || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat (pick_gap()) @(posedge clk);
			end
		end
	end

	// ---------------- checker and watchdog ----------------

	always @(posedge clk) begin
		postfix_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat out_char=%h last=%b err=%b",
					         $time, out_char, last_of_run, syntax_error);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (out_char !== want.ch) begin
						$display("%0t: out_char expected %h actual %h",
						         $time, want.ch, out_char);
						fail_count++;
					end
					if (last_of_run !== want.last) begin
						$display("%0t: last_of_run expected %b actual %b",
						         $time, want.last, last_of_run);
						fail_count++;
					end
					if (syntax_error !== want.err) begin
						$display("%0t: syntax_error expected %b actual %b",
						         $time, want.err, syntax_error);
						fail_count++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: timeout, %0d beats still expected", $time,
				         expected_beats.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_expression();
		test_odd_characters();
		test_stack_overflow();
		test_random_expressions();
		test_noise();
		test_output_hold();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/i2p_pkg.sv
hw/rtl/i2p_ctrl.sv
hw/rtl/i2p_dp.sv
hw/rtl/infix_to_postfix_converter.sv
verif/infix_to_postfix_converter_test.sv
